/* hw/rtl/arp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_pkg
// Shared constants and types for the ARP cache table.
// ----------------------------------------------------------------------------
package arp_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W   = $clog2(ENTRIES + 1);

   localparam int MODE_W  = 2;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int TTL_W   = 16;
   localparam int USE_W   = 5;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   typedef struct packed {
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
      logic             known;
      logic [TTL_W-1:0] ttl;
   } entry_type;

endpackage
`default_nettype wire

/* hw/rtl/arp_cache_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache_table
// IPv4 to MAC cache: lookup, add/update and remove over a scanned slot memory.
// ----------------------------------------------------------------------------
//  channel | ports       | direction | beat
//  req     | req_*       | in        | mode, ip, mac, known flag, ttl
//  rsp     | rsp_*       | out       | found, stored entry, occupancy, full flag
//
//  An accepted request scans all ENTRIES slots through the single read port
//  of the slot memory, one slot per cycle, with one 32-bit key comparator.
//  The result is registered after the scan, the DRAIN and the COMMIT states;
//  req_ready rises together with it, so a new request waits for the last result.
//  Synchronous reset clears valid bits and occupancy;
//  slot contents are not cleared. A stalled rsp holds the block after commit.
// ----------------------------------------------------------------------------
module arp_cache_table (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [arp_pkg::MODE_W-1:0]   req_mode,
   input  wire  [arp_pkg::IP_W-1:0]     req_ip_addr,
   input  wire  [arp_pkg::MAC_W-1:0]    req_mac_addr,
   input  wire                          req_mac_known,
   input  wire  [arp_pkg::TTL_W-1:0]    req_ttl,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_found,
   output logic [arp_pkg::MAC_W-1:0]    rsp_found_mac,
   output logic                         rsp_found_mac_known,
   output logic [arp_pkg::TTL_W-1:0]    rsp_found_ttl,
   output logic [arp_pkg::USE_W-1:0]    rsp_entries_in_use,
   output logic                         rsp_rejected_full
);
   import arp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_HOLD   = 3'd4;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              cmp_live_ff;

   logic [MODE_W-1:0] op_mode_ff;
   logic [IP_W-1:0]   op_ip_ff;
   logic [MAC_W-1:0]  op_mac_ff;
   logic              op_known_ff;
   logic [TTL_W-1:0]  op_ttl_ff;

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              free_ff, free_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [MAC_W-1:0]  hit_mac_ff, hit_mac_in;
   logic              hit_known_ff, hit_known_in;
   logic [TTL_W-1:0]  hit_ttl_ff, hit_ttl_in;

   logic [ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   entry_type         mem [ENTRIES];
   entry_type         rd_data_ff;
   entry_type         wr_data;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;

   logic              cmp_match, cmp_free;
   logic              reject;
   logic              rsp_load;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [MAC_W-1:0]  rsp_mac_ff;
   logic              rsp_known_ff;
   logic [TTL_W-1:0]  rsp_ttl_ff;
   logic [USE_W-1:0]  rsp_use_ff, rsp_use_in;
   logic              rsp_full_ff;

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[cnt_ff];
   end

   assign cmp_match = cmp_live_ff && slot_valid_ff[cmp_idx_ff] && (rd_data_ff.ip == op_ip_ff);
   assign cmp_free  = cmp_live_ff && !slot_valid_ff[cmp_idx_ff];

   assign reject = (op_mode_ff == MODE_ADD) && !hit_ff && !free_ff;

   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_mac_in   = hit_mac_ff;
      hit_known_in = hit_known_ff;
      hit_ttl_in   = hit_ttl_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      if (req_valid && req_ready) begin
         hit_in       = 1'b0;
         free_in      = 1'b0;
         hit_idx_in   = '0;
         free_idx_in  = '0;
         hit_mac_in   = '0;
         hit_known_in = 1'b0;
         hit_ttl_in   = '0;
      end else begin
         // first match and first free slot win
         if (cmp_match && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = cmp_idx_ff;
            hit_mac_in   = rd_data_ff.mac;
            hit_known_in = rd_data_ff.known;
            hit_ttl_in   = rd_data_ff.ttl;
         end
         if (cmp_free && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end
   end

   // commit: writes, valid bits, occupancy
   always_comb begin
      wr_en         = 1'b0;
      wr_idx        = hit_ff ? hit_idx_ff : free_idx_ff;
      wr_data.ip    = op_ip_ff;
      wr_data.mac   = op_known_ff ? op_mac_ff : '0;
      wr_data.known = op_known_ff;
      wr_data.ttl   = op_ttl_ff;
      slot_valid_in = slot_valid_ff;
      occ_in        = occ_ff;
      if (state_ff == ST_COMMIT) begin
         if (op_mode_ff == MODE_ADD) begin
            if (hit_ff) begin
               wr_en = 1'b1;
            end else if (free_ff) begin
               wr_en                      = 1'b1;
               slot_valid_in[free_idx_ff] = 1'b1;
               occ_in                     = occ_ff + OCC_W'(1);
            end
         end else if (op_mode_ff == MODE_REMOVE && hit_ff) begin
            slot_valid_in[hit_idx_ff] = 1'b0;
            if (occ_ff != '0) begin
               occ_in = occ_ff - OCC_W'(1);
            end
         end
      end
   end

   assign rsp_load   = ((state_ff == ST_COMMIT) || (state_ff == ST_HOLD))
                       && (!rsp_valid_ff || rsp_ready);
   assign rsp_use_in = USE_W'(occ_in);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT, ST_HOLD: begin
            state_in = rsp_load ? ST_IDLE : ST_HOLD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_live_ff   <= 1'b0;
         slot_valid_ff <= '0;
         occ_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_live_ff   <= (state_ff == ST_SCAN);
         slot_valid_ff <= slot_valid_in;
         occ_ff        <= occ_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      cmp_idx_ff   <= cnt_ff;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_mac_ff   <= hit_mac_in;
      hit_known_ff <= hit_known_in;
      hit_ttl_ff   <= hit_ttl_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      if (req_valid && req_ready) begin
         op_mode_ff  <= req_mode;
         op_ip_ff    <= req_ip_addr;
         op_mac_ff   <= req_mac_addr;
         op_known_ff <= req_mac_known;
         op_ttl_ff   <= req_ttl;
      end
      // occupancy is final once commit has run, so HOLD reads occ_ff via occ_in
      if (rsp_load) begin
         rsp_found_ff <= hit_ff;
         rsp_mac_ff   <= hit_mac_ff;
         rsp_known_ff <= hit_known_ff;
         rsp_ttl_ff   <= hit_ttl_ff;
         rsp_use_ff   <= rsp_use_in;
         rsp_full_ff  <= reject;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_found_mac       = rsp_mac_ff;
   assign rsp_found_mac_known = rsp_known_ff;
   assign rsp_found_ttl       = rsp_ttl_ff;
   assign rsp_entries_in_use  = rsp_use_ff;
   assign rsp_rejected_full   = rsp_full_ff;

`ifndef NO_ASSERTIONS
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) == $countones(slot_valid_ff))
      else $error("occupancy out of step with valid bits");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_full_ff && rsp_found_ff))
      else $error("full rejection reported together with a hit");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN && cnt_ff == '0))
      else $error("accepted beat did not start a scan");

   a_write_only_commit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_COMMIT && op_mode_ff == MODE_ADD))
      else $error("slot write outside commit");

   a_no_load_over_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_use_ff))
      else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

/* bench/tb_arp_cache_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arp_cache_table
// Self-checking bench for the ARP cache table. A queue of request beats,
// directed first and then random phases over a small key pool, feeds a
// clocked driver. At acceptance a local cache model predicts the response.
// A clocked monitor with random back-pressure checks every response beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_arp_cache_table;
   import arp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1870;
   localparam int PHASE_LEN    = 120;
   localparam int POOL_MAX     = 32;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [IP_W-1:0]   ip;
      logic [MAC_W-1:0]  mac;
      logic              known;
      logic [TTL_W-1:0]  ttl;
      int                send_gap;
      int                rsp_stall;
      bit                drain_first;
   } arp_req_t;

   typedef struct {
      logic              found;
      logic [MAC_W-1:0]  mac;
      logic              known;
      logic [TTL_W-1:0]  ttl;
      logic [USE_W-1:0]  in_use;
      logic              full;
      int                rsp_stall;
   } arp_rsp_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = MODE_LOOKUP;
   logic [IP_W-1:0]     req_ip_addr = '0;
   logic [MAC_W-1:0]    req_mac_addr = '0;
   logic                req_mac_known = 1'b0;
   logic [TTL_W-1:0]    req_ttl = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_found;
   logic [MAC_W-1:0]    rsp_found_mac;
   logic                rsp_found_mac_known;
   logic [TTL_W-1:0]    rsp_found_ttl;
   logic [USE_W-1:0]    rsp_entries_in_use;
   logic                rsp_rejected_full;

   arp_req_t            pending_q[$];
   arp_rsp_t            lookup_results_q[$];
   arp_req_t            in_flight;
   int                  gap_cnt;
   int                  stall_cnt;
   int                  fault_count = 0;
   bit                  calm = 1'b0;

   // cache model
   bit                  tbl_used[ENTRIES];
   logic [IP_W-1:0]     tbl_ip[ENTRIES];
   logic [MAC_W-1:0]    tbl_mac[ENTRIES];
   logic                tbl_known[ENTRIES];
   logic [TTL_W-1:0]    tbl_ttl[ENTRIES];
   int                  tbl_count = 0;

   arp_cache_table dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_ip_addr         (req_ip_addr),
      .req_mac_addr        (req_mac_addr),
      .req_mac_known       (req_mac_known),
      .req_ttl             (req_ttl),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_found_mac       (rsp_found_mac),
      .rsp_found_mac_known (rsp_found_mac_known),
      .rsp_found_ttl       (rsp_found_ttl),
      .rsp_entries_in_use  (rsp_entries_in_use),
      .rsp_rejected_full   (rsp_rejected_full)
   );

   always #2 clock = ~clock;

   // Applies one request to the model and returns the response it should give.
   function automatic arp_rsp_t resolve_request(arp_req_t r);
      arp_rsp_t         o;
      int               i;
      int               hit_idx;
      int               free_idx;
      logic [MAC_W-1:0] stored_mac;
      hit_idx  = -1;
      free_idx = -1;
      for (i = 0; i < ENTRIES; i++) begin
         if (tbl_used[i]) begin
            if (hit_idx < 0 && tbl_ip[i] == r.ip) hit_idx = i;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      o.found = (hit_idx >= 0);
      o.mac   = '0;
      o.known = 1'b0;
      o.ttl   = '0;
      o.full  = 1'b0;
      if (hit_idx >= 0) begin
         o.mac   = tbl_mac[hit_idx];
         o.known = tbl_known[hit_idx];
         o.ttl   = tbl_ttl[hit_idx];
      end
      stored_mac = r.known ? r.mac : '0;
      case (r.mode)
         MODE_ADD: begin
            if (hit_idx >= 0) begin
               tbl_mac[hit_idx]   = stored_mac;
               tbl_known[hit_idx] = r.known;
               tbl_ttl[hit_idx]   = r.ttl;
            end else if (free_idx >= 0) begin
               tbl_used[free_idx]  = 1'b1;
               tbl_ip[free_idx]    = r.ip;
               tbl_mac[free_idx]   = stored_mac;
               tbl_known[free_idx] = r.known;
               tbl_ttl[free_idx]   = r.ttl;
               tbl_count++;
            end else begin
               o.full = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (hit_idx >= 0) begin
               tbl_used[hit_idx] = 1'b0;
               if (tbl_count > 0) tbl_count--;
            end
         end
         default: ;
      endcase
      o.in_use    = tbl_count[USE_W-1:0];
      o.rsp_stall = r.rsp_stall;
      return o;
   endfunction

   task automatic report_fault(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fault_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_fault($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
   endtask

   task automatic queue_req(logic [MODE_W-1:0] mode, logic [IP_W-1:0] ip,
                            logic [MAC_W-1:0] mac, logic known,
                            logic [TTL_W-1:0] ttl, bit drain);
      arp_req_t r;
      r.mode        = mode;
      r.ip          = ip;
      r.mac         = mac;
      r.known       = known;
      r.ttl         = ttl;
      r.send_gap    = calm ? 0 : $urandom_range(0, 5);
      r.rsp_stall   = calm ? 0 : $urandom_range(0, 5);
      r.drain_first = drain;
      pending_q.push_back(r);
   endtask

   // Driver: presents a beat after its gap and any drain, holds it until taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (req_valid && req_ready)
            lookup_results_q.push_back(resolve_request(in_flight));
         if (!req_valid || req_ready) begin
            if (pending_q.size() != 0 && gap_cnt >= pending_q[0].send_gap &&
                !(pending_q[0].drain_first && lookup_results_q.size() != 0)) begin
               in_flight = pending_q.pop_front();
               req_mode      <= in_flight.mode;
               req_ip_addr   <= in_flight.ip;
               req_mac_addr  <= in_flight.mac;
               req_mac_known <= in_flight.known;
               req_ttl       <= in_flight.ttl;
               req_valid     <= 1'b1;
               gap_cnt = 0;
            end else begin
               req_valid <= 1'b0;
               if (pending_q.size() != 0 && gap_cnt < pending_q[0].send_gap) gap_cnt++;
            end
         end
      end
   end

   // Monitor: applies each response beat's drawn rsp_stall before taking it.
   always @(posedge clock) begin
      arp_rsp_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (lookup_results_q.size() == 0) begin
               report_fault("response beat with nothing outstanding");
            end else begin
               want = lookup_results_q.pop_front();
               check_field("found", 64'(rsp_found), 64'(want.found));
               check_field("found_mac", 64'(rsp_found_mac), 64'(want.mac));
               check_field("found_mac_known", 64'(rsp_found_mac_known),
                           64'(want.known));
               check_field("found_ttl", 64'(rsp_found_ttl), 64'(want.ttl));
               check_field("entries_in_use", 64'(rsp_entries_in_use),
                           64'(want.in_use));
               check_field("rejected_full", 64'(rsp_rejected_full), 64'(want.full));
            end
            stall_cnt = 0;
         end else if (rsp_valid) begin
            stall_cnt++;
         end
         rsp_ready <= (lookup_results_q.size() == 0) ||
                      (stall_cnt >= lookup_results_q[0].rsp_stall);
      end
   end

   initial begin
      logic [IP_W-1:0] key_pool[POOL_MAX];
      int              pool_n;
      int              add_pct;
      int              n;
      int              k;
      int              roll;
      logic [IP_W-1:0] ip;
      logic [MODE_W-1:0] mode;

      // directed: empty table, extremes, update, remove, spare mode, full table
      queue_req(MODE_LOOKUP, 32'h0A00_0001, '0, 1'b0, '0, 1'b0);
      queue_req(MODE_SPARE, 32'h0A00_0001, '0, 1'b0, '0, 1'b0);
      queue_req(MODE_ADD, 32'h0000_0000, {MAC_W{1'b1}}, 1'b1, 16'hFFFF, 1'b0);
      queue_req(MODE_ADD, 32'hFFFF_FFFF, 48'h1234_5678_9ABC, 1'b0, 16'h0000, 1'b0);
      queue_req(MODE_LOOKUP, 32'h0000_0000, '0, 1'b0, '0, 1'b1);
      queue_req(MODE_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0, '0, 1'b0);
      queue_req(MODE_LOOKUP, 32'h7FFF_FFFF, '0, 1'b0, '0, 1'b0);
      queue_req(MODE_ADD, 32'h0000_0000, 48'h0, 1'b1, 16'h0001, 1'b0);
      queue_req(MODE_SPARE, 32'h0000_0000, 48'hFFFF_0000_FFFF, 1'b1, 16'h1234, 1'b0);
      queue_req(MODE_REMOVE, 32'hFFFF_FFFF, '0, 1'b0, '0, 1'b0);
      queue_req(MODE_REMOVE, 32'hFFFF_FFFF, '0, 1'b0, '0, 1'b0);
      for (k = 1; k < ENTRIES; k++)
         queue_req(MODE_ADD, 32'hC0A8_0000 + k, MAC_W'({$urandom, $urandom}), k[0],
                   TTL_W'($urandom), 1'b0);
      queue_req(MODE_ADD, 32'hC0A8_00FF, 48'hA5A5_A5A5_A5A5, 1'b1, 16'h00FF, 1'b1);
      queue_req(MODE_ADD, 32'h0000_0000, 48'h5A5A_5A5A_5A5A, 1'b1, 16'hFF00, 1'b0);

      // random phases over a key pool small enough to fill and empty the table
      for (k = 0; k < POOL_MAX; k++) key_pool[k] = $urandom;
      pool_n  = 16;
      add_pct = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            pool_n = $urandom_range(6, POOL_MAX);
            case ($urandom_range(0, 2))
               0:       add_pct = 75;
               1:       add_pct = 50;
               default: add_pct = 25;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < 4; k++) key_pool[$urandom_range(0, POOL_MAX - 1)] = $urandom;
         end
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            mode = MODE_SPARE;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct) mode = MODE_ADD;
            else if (roll < add_pct + (100 - add_pct) / 2) mode = MODE_LOOKUP;
            else mode = MODE_REMOVE;
         end
         roll = $urandom_range(0, 19);
         ip = key_pool[$urandom_range(0, pool_n - 1)];
         // random keys and near misses: one key bit flipped
         if (roll == 0) ip = $urandom;
         else if (roll == 1) ip = ip ^ (32'd1 << $urandom_range(0, 31));
         queue_req(mode, ip, MAC_W'({$urandom, $urandom}), ($urandom_range(0, 7) != 0),
                   TTL_W'($urandom), (n % 250 == 249));
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_valid || lookup_results_q.size() != 0)
         @(posedge clock);
      repeat (2 * ENTRIES + 8) @(posedge clock);
      if (fault_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/arp_pkg.sv
hw/rtl/arp_cache_table.sv
bench/tb_arp_cache_table.sv
